// File: design/rtp_pkg.sv
// shared types and constants for the radix integer text parser
package rtp_pkg;

  // character classes produced by the front end
  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_MINUS,
    CLS_PLUS,
    CLS_HASH,
    CLS_UNDER,
    CLS_NUL,
    CLS_DIGIT,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    cls_e       cls;
    logic [5:0] digit;
    logic [7:0] ch;
  } tok_t;

  localparam logic [5:0] DIGIT_NONE = 6'd63;
  localparam logic [5:0] RADIX_MIN  = 6'd2;
  localparam logic [5:0] RADIX_MAX  = 6'd36;
  localparam logic [5:0] RADIX_RST  = 6'd10;

  localparam logic [2:0] ST_NUMBER   = 3'd0;
  localparam logic [2:0] ST_MIN      = 3'd1;
  localparam logic [2:0] ST_MAX      = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_BADRADIX = 3'd4;

  localparam logic [23:0] SIG_MIN = 24'h4D494E;
  localparam logic [23:0] SIG_MAX = 24'h4D4158;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_CNT_W = 2;

endpackage

// File: design/radix_integer_text_parser.sv
// top level: one character per cycle enters a classifier, a two-item queue and the parser
// throughput: one item per cycle, sustained, while the output is not stalled
// a terminating item is written into the token queue by the edge that accepts it, and into
// the result register once the back end pops it, which an output stall can hold off
// reset: asynchronous, active low; clears the queue, parse state and result valid,
// and sets the radix register to ten
module radix_integer_text_parser #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        radix_we_i,
  input  logic [5:0]  radix_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] value_o,
  output logic [2:0]  status_o
);

  localparam logic [63:0] MinWide = 64'd1 << (VALUE_BITS - 1);

  logic [5:0]    radix_q;
  logic          full;
  logic          push;
  logic          q_valid;
  logic          pop;
  rtp_pkg::tok_t front_tok;
  rtp_pkg::tok_t back_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= rtp_pkg::RADIX_RST;
    end else if (radix_we_i) begin
      radix_q <= radix_i;
    end
  end

  rtp_front u_front (
    .in_valid_i (in_valid_i),
    .ch_i       (ch_i),
    .in_stall_o (in_stall_o),
    .full_i     (full),
    .push_o     (push),
    .tok_o      (front_tok)
  );

  rtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (front_tok),
    .full_o  (full),
    .valid_o (q_valid),
    .tok_o   (back_tok),
    .pop_i   (pop)
  );

  rtp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_i     (radix_q),
    .tok_valid_i (q_valid),
    .tok_i       (back_tok),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

`ifndef NO_ASSERTIONS
  // a fresh result only comes from a token taken out of the queue
  a_result_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(pop))
    else $error("result appeared without a popped item");

  // the queue never pops when empty
  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid)
    else $error("pop from empty queue");

  // MIN signature carries the most negative value
  a_min_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == rtp_pkg::ST_MIN) |-> (value_o == MinWide[31:0]))
    else $error("MIN signature with wrong value");

  // unknown signature and bad radix give zero
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == rtp_pkg::ST_UNKNOWN || status_o == rtp_pkg::ST_BADRADIX))
      |-> (value_o == 32'd0))
    else $error("nonzero value on unknown signature or bad radix");
`endif

endmodule

// File: design/rtp_front.sv
// front end: accepts characters and classifies them into tokens
module rtp_front (
  input  logic          in_valid_i,
  input  logic [7:0]    ch_i,
  output logic          in_stall_o,
  input  logic          full_i,
  output logic          push_o,
  output rtp_pkg::tok_t tok_o
);

  always_comb begin
    tok_o.ch    = ch_i;
    tok_o.digit = rtp_pkg::DIGIT_NONE;
    tok_o.cls   = rtp_pkg::CLS_OTHER;
    priority if (ch_i == 8'h20 || (ch_i >= 8'h09 && ch_i <= 8'h0D)) begin
      tok_o.cls = rtp_pkg::CLS_SPACE;
    end else if (ch_i == 8'h2D) begin
      tok_o.cls = rtp_pkg::CLS_MINUS;
    end else if (ch_i == 8'h2B) begin
      tok_o.cls = rtp_pkg::CLS_PLUS;
    end else if (ch_i == 8'h23) begin
      tok_o.cls = rtp_pkg::CLS_HASH;
    end else if (ch_i == 8'h5F) begin
      tok_o.cls = rtp_pkg::CLS_UNDER;
    end else if (ch_i == 8'h00) begin
      tok_o.cls = rtp_pkg::CLS_NUL;
    end else if (ch_i >= 8'h30 && ch_i <= 8'h39) begin
      tok_o.cls   = rtp_pkg::CLS_DIGIT;
      tok_o.digit = 6'(ch_i - 8'h30);
    end else if (ch_i >= 8'h41 && ch_i <= 8'h5A) begin
      tok_o.cls   = rtp_pkg::CLS_DIGIT;
      tok_o.digit = 6'(ch_i - 8'h41 + 8'd10);
    end else if (ch_i >= 8'h61 && ch_i <= 8'h7A) begin
      tok_o.cls   = rtp_pkg::CLS_DIGIT;
      tok_o.digit = 6'(ch_i - 8'h61 + 8'd10);
    end else begin
      tok_o.cls = rtp_pkg::CLS_OTHER;
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

// File: design/rtp_queue.sv
// two-entry token queue between front and back
module rtp_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rtp_pkg::tok_t tok_i,
  output logic          full_o,
  output logic          valid_o,
  output rtp_pkg::tok_t tok_o,
  input  logic          pop_i
);

  rtp_pkg::tok_t                         mem_q [rtp_pkg::QUEUE_DEPTH];
  logic [rtp_pkg::QUEUE_PTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [rtp_pkg::QUEUE_PTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [rtp_pkg::QUEUE_CNT_W-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == rtp_pkg::QUEUE_CNT_W'(rtp_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

endmodule

// File: design/rtp_back.sv
// back end: parse state machine, accumulator and result register
module rtp_back #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [5:0]    radix_i,
  input  logic          tok_valid_i,
  input  rtp_pkg::tok_t tok_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   value_o,
  output logic [2:0]    status_o
);

  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_SIG   = 2'd3;

  localparam logic [VALUE_BITS-1:0] MinVal = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] MaxVal = ~MinVal;

  logic [1:0]            phase_q, phase_d;
  logic                  minus_q, minus_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;
  logic [23:0]           sig_q, sig_d;
  logic [1:0]            sig_cnt_q, sig_cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [31:0]           value_q, value_d;
  logic [2:0]            status_q, status_d;

  logic                  emit;
  logic [VALUE_BITS-1:0] emit_val;
  logic [2:0]            emit_st;
  logic                  radix_ok;
  logic                  is_digit;
  logic [VALUE_BITS-1:0] radix_ext;
  logic [VALUE_BITS-1:0] acc_mac;
  logic [23:0]           sig_shift;
  logic [1:0]            sig_cnt_inc;
  logic [63:0]           emit_wide;

  assign pop_o     = tok_valid_i && (!out_valid_q || !out_stall_i);
  assign radix_ok  = (radix_i >= rtp_pkg::RADIX_MIN) && (radix_i <= rtp_pkg::RADIX_MAX);
  assign is_digit  = (tok_i.cls == rtp_pkg::CLS_DIGIT) && (tok_i.digit < radix_i);
  assign radix_ext = VALUE_BITS'(radix_i);
  assign acc_mac   = acc_q * radix_ext + VALUE_BITS'(tok_i.digit);
  assign sig_shift = {sig_q[15:0], tok_i.ch};
  assign sig_cnt_inc = sig_cnt_q + 2'd1;
  assign emit_wide = 64'(emit_val);

  always_comb begin
    phase_d   = phase_q;
    minus_d   = minus_q;
    acc_d     = acc_q;
    sig_d     = sig_q;
    sig_cnt_d = sig_cnt_q;
    emit      = 1'b0;
    emit_val  = '0;
    emit_st   = rtp_pkg::ST_NUMBER;

    if (pop_o) begin
      unique case (phase_q)
        PH_LEAD, PH_SIGN, PH_DIGIT: begin
          // lead, sign, digit phases: skip blanks, one sign, digits
          if (phase_q == PH_LEAD && tok_i.cls == rtp_pkg::CLS_SPACE) begin
            phase_d = PH_LEAD;
          end else if (phase_q == PH_LEAD && tok_i.cls == rtp_pkg::CLS_MINUS) begin
            minus_d = 1'b1;
            phase_d = PH_SIGN;
          end else if (phase_q == PH_LEAD && tok_i.cls == rtp_pkg::CLS_PLUS) begin
            phase_d = PH_SIGN;
          end else if (phase_q != PH_DIGIT && tok_i.cls == rtp_pkg::CLS_HASH) begin
            phase_d   = PH_SIG;
            sig_d     = '0;
            sig_cnt_d = '0;
          end else if (phase_q != PH_DIGIT && !radix_ok) begin
            emit    = 1'b1;
            emit_st = rtp_pkg::ST_BADRADIX;
          end else if (tok_i.cls == rtp_pkg::CLS_UNDER) begin
            phase_d = PH_DIGIT;
          end else if (is_digit) begin
            acc_d   = acc_mac;
            phase_d = PH_DIGIT;
          end else begin
            emit     = 1'b1;
            emit_val = minus_q ? ('0 - acc_q) : acc_q;
          end
        end
        PH_SIG: begin
          if (tok_i.cls == rtp_pkg::CLS_NUL) begin
            emit    = 1'b1;
            emit_st = rtp_pkg::ST_UNKNOWN;
          end else begin
            sig_d     = sig_shift;
            sig_cnt_d = sig_cnt_inc;
            if (sig_cnt_inc == 2'd3) begin
              emit = 1'b1;
              if (sig_shift == rtp_pkg::SIG_MIN) begin
                emit_val = MinVal;
                emit_st  = rtp_pkg::ST_MIN;
              end else if (sig_shift == rtp_pkg::SIG_MAX) begin
                emit_val = MaxVal;
                emit_st  = rtp_pkg::ST_MAX;
              end else begin
                emit_st = rtp_pkg::ST_UNKNOWN;
              end
            end
          end
        end
        default: begin
          phase_d = PH_LEAD;
        end
      endcase

      // every result returns the parse state to its start
      if (emit) begin
        phase_d   = PH_LEAD;
        minus_d   = 1'b0;
        acc_d     = '0;
        sig_d     = '0;
        sig_cnt_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    value_d     = value_q;
    status_d    = status_q;
    if (emit) begin
      out_valid_d = 1'b1;
      value_d     = emit_wide[31:0];
      status_d    = emit_st;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      minus_q     <= 1'b0;
      acc_q       <= '0;
      sig_q       <= '0;
      sig_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      minus_q     <= minus_d;
      acc_q       <= acc_d;
      sig_q       <= sig_d;
      sig_cnt_q   <= sig_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule

// File: tb/testbench.sv
// self-checking testbench for the radix integer text parser
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGIT,
    PH_SIG
  } parse_phase_e;

  typedef enum logic [1:0] {
    ROW_RADIX,
    ROW_CHAR,
    ROW_CHAR_KNOWN
  } row_kind_e;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } parse_result_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  ch;
    logic [31:0] value;
    logic [2:0]  status;
  } stim_row_t;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = " ";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_HASH    = "#";
  localparam logic [7:0] CH_UNDER   = "_";
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";
  localparam logic [7:0] CH_UPPER_A = "A";
  localparam logic [7:0] CH_UPPER_Z = "Z";
  localparam logic [7:0] CH_LOWER_A = "a";
  localparam logic [7:0] CH_LOWER_Z = "z";

  localparam logic [31:0] VALUE_TOP = 32'd1 << 31;

  localparam int NUM_DIRECTED    = 30;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 68;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        radix_we_i = 1'b0;
  logic [5:0]  radix_i = rtp_pkg::RADIX_RST;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  ch_i = CH_NUL;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] value_o;
  logic [2:0]  status_o;

  // parser state as the block should hold it
  parse_phase_e num_phase;
  logic         num_minus;
  logic [31:0]  num_acc;
  logic [23:0]  sig_word;
  logic [1:0]   sig_count;
  logic [5:0]   cur_radix;

  parse_result_t pending_results [$];
  int errors = 0;
  int items_sent = 0;
  int gap_pct = 30;
  int stall_pct = 30;
  bit calm = 1'b0;
  int stall_left = 0;
  bit stall_now = 1'b0;

  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_CHAR,       CH_TAB,   32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_MINUS, 32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_HASH,  32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "M",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "I",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, "N",      VALUE_TOP,     rtp_pkg::ST_MIN},
    '{ROW_CHAR,       CH_PLUS,  32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, CH_MINUS, 32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_UNDER, 32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "9",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_UNDER, 32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, CH_NUL,   32'd9,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, CH_NUL,   32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_RADIX,      CH_NUL,   32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_HASH,  32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "M",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "A",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, "X",      ~VALUE_TOP,    rtp_pkg::ST_MAX},
    '{ROW_CHAR_KNOWN, "5",      32'd0,         rtp_pkg::ST_BADRADIX},
    '{ROW_RADIX,      CH_NUL,   32'd36,        rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       CH_HASH,  32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR_KNOWN, CH_NUL,   32'd0,         rtp_pkg::ST_UNKNOWN},
    '{ROW_CHAR,       "z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "Z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "Z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       "Z",      32'd0,         rtp_pkg::ST_NUMBER},
    '{ROW_CHAR,       8'hFF,    32'd0,         rtp_pkg::ST_NUMBER}
  };

  logic [5:0] radix_plan [8] = '{
    rtp_pkg::RADIX_MIN, rtp_pkg::RADIX_MAX, 6'd0, 6'd16, 6'd63, 6'd8, 6'd37, 6'd1
  };

  radix_integer_text_parser i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .radix_we_i  (radix_we_i),
    .radix_i     (radix_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .ch_i        (ch_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void clear_number();
    num_phase = PH_LEAD;
    num_minus = 1'b0;
    num_acc   = '0;
    sig_word  = '0;
    sig_count = '0;
  endfunction

  function automatic int digit_value(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c) - int'(CH_UPPER_A) + 10;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c) - int'(CH_LOWER_A) + 10;
    return 255;
  endfunction

  // advances the parse by one character; returns 1 when a result comes out
  function automatic bit parse_char(input logic [7:0] c, output parse_result_t res);
    int d;
    bit at_start;
    res = '0;
    d = digit_value(c);
    at_start = 1'b0;
    case (num_phase)
      PH_LEAD: begin
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) return 1'b0;
        if (c == CH_MINUS) begin
          num_minus = 1'b1;
          num_phase = PH_SIGN;
          return 1'b0;
        end
        if (c == CH_PLUS) begin
          num_phase = PH_SIGN;
          return 1'b0;
        end
        at_start = 1'b1;
      end
      PH_SIGN: at_start = 1'b1;
      PH_DIGIT: at_start = 1'b0;
      default: begin
        if (c == CH_NUL) begin
          res.status = rtp_pkg::ST_UNKNOWN;
          clear_number();
          return 1'b1;
        end
        sig_word  = {sig_word[15:0], c};
        sig_count = sig_count + 2'd1;
        if (sig_count != 2'd3) return 1'b0;
        if (sig_word == rtp_pkg::SIG_MIN) begin
          res.value  = VALUE_TOP;
          res.status = rtp_pkg::ST_MIN;
        end else if (sig_word == rtp_pkg::SIG_MAX) begin
          res.value  = ~VALUE_TOP;
          res.status = rtp_pkg::ST_MAX;
        end else begin
          res.status = rtp_pkg::ST_UNKNOWN;
        end
        clear_number();
        return 1'b1;
      end
    endcase
    if (at_start) begin
      if (c == CH_HASH) begin
        num_phase = PH_SIG;
        sig_word  = '0;
        sig_count = '0;
        return 1'b0;
      end
      if (cur_radix < rtp_pkg::RADIX_MIN || cur_radix > rtp_pkg::RADIX_MAX) begin
        res.status = rtp_pkg::ST_BADRADIX;
        clear_number();
        return 1'b1;
      end
    end
    if (c == CH_UNDER) begin
      num_phase = PH_DIGIT;
      return 1'b0;
    end
    if (d < int'(cur_radix)) begin
      num_acc   = num_acc * 32'(cur_radix) + 32'(d);
      num_phase = PH_DIGIT;
      return 1'b0;
    end
    res.value  = num_minus ? (32'd0 - num_acc) : num_acc;
    res.status = rtp_pkg::ST_NUMBER;
    clear_number();
    return 1'b1;
  endfunction

  // offers one character and waits until the block takes it
  task automatic send_char(input logic [7:0] c, input bit typed, input parse_result_t typed_res);
    parse_result_t res;
    bit got;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ch_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    got = parse_char(c, res);
    if (typed) pending_results.push_back(typed_res);
    else if (got) pending_results.push_back(res);
  endtask

  // radix changes only once the parser has gone quiet
  task automatic set_radix(input logic [5:0] r);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    radix_we_i <= 1'b1;
    radix_i <= r;
    @(posedge clk_i);
    radix_we_i <= 1'b0;
    cur_radix = r;
  endtask

  // one number or signature, mostly well formed, sometimes plain noise
  task automatic send_token();
    int kind;
    int n_digits;
    int d;
    int stop_at;
    logic [23:0] word;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)), 1'b0, '0);
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      c = $urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
      send_char(c, 1'b0, '0);
    end
    case ($urandom_range(0, 3))
      0: send_char(CH_MINUS, 1'b0, '0);
      1: send_char(CH_PLUS, 1'b0, '0);
      default: ;
    endcase
    if (kind < 26) begin
      case ($urandom_range(0, 3))
        0: word = rtp_pkg::SIG_MIN;
        1: word = rtp_pkg::SIG_MAX;
        2: word = {rtp_pkg::SIG_MAX[23:8], 8'($urandom_range(0, 255))};
        default: word = 24'($urandom);
      endcase
      // now and then the buffer ends inside the signature
      stop_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
      send_char(CH_HASH, 1'b0, '0);
      for (int i = 0; i < 3; i++) begin
        send_char((i == stop_at) ? CH_NUL : word[23 - 8 * i -: 8], 1'b0, '0);
        if (i == stop_at) return;
      end
      return;
    end
    n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 6);
    for (int i = 0; i < n_digits; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(CH_UNDER, 1'b0, '0);
      if (cur_radix >= rtp_pkg::RADIX_MIN && cur_radix <= rtp_pkg::RADIX_MAX) begin
        d = $urandom_range(0, cur_radix - 1);
      end else begin
        d = $urandom_range(0, 35);
      end
      if (d < 10) c = 8'(int'(CH_ZERO) + d);
      else c = 8'(int'($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + d - 10);
      send_char(c, 1'b0, '0);
    end
    case ($urandom_range(0, 3))
      0: c = CH_NUL;
      1: c = CH_SPACE;
      2: c = CH_DOT;
      default: c = 8'($urandom_range(0, 255));
    endcase
    send_char(c, 1'b0, '0);
  endtask

  // result side back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_now  = !calm && ($urandom_range(0, 99) < stall_pct);
      stall_left = $urandom_range(1, 7);
    end
    stall_left--;
    out_stall_i <= stall_now && !calm;
  end

  always @(posedge clk_i) begin : check_results
    parse_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: value %h status %0d", value_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (value_o !== want.value) begin
          $error("value: expected %h, got %h", want.value, value_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
      end
    end
  end

  initial begin
    parse_result_t known_res;
    logic [5:0] next_radix;
    int phase_start;
    clear_number();
    cur_radix = rtp_pkg::RADIX_RST;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_rows[i].kind == ROW_RADIX) begin
        set_radix(directed_rows[i].value[5:0]);
      end else begin
        known_res.value  = directed_rows[i].value;
        known_res.status = directed_rows[i].status;
        send_char(directed_rows[i].ch, directed_rows[i].kind == ROW_CHAR_KNOWN, known_res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 8) next_radix = radix_plan[p];
      else if ($urandom_range(0, 3) != 0) next_radix = 6'($urandom_range(2, 36));
      else next_radix = 6'($urandom_range(0, 63));
      set_radix(next_radix);
      calm = (p == NUM_PHASES - 1);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 15;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 20;
        default: stall_pct = 60;
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE) send_token();
      // close any open number so the next radix write finds the parser at rest
      send_char(CH_NUL, 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// File: sim.f
design/rtp_pkg.sv
design/rtp_front.sv
design/rtp_queue.sv
design/rtp_back.sv
design/radix_integer_text_parser.sv
tb/testbench.sv
